FILE: hdl/utt_pkg.sv
// ----------------------------------------------------------------------------
// utt_pkg
// Shared types and constants for the UTF-16 to UTF-8 transcoder.
// ----------------------------------------------------------------------------
`default_nettype none

package utt_pkg;

    // surrogate ranges
    localparam logic [15:0] HI_FIRST = 16'hD800;
    localparam logic [15:0] HI_LAST  = 16'hDBFF;
    localparam logic [15:0] LO_FIRST = 16'hDC00;
    localparam logic [15:0] LO_LAST  = 16'hDFFF;

    // encoding limits and marker bits
    localparam logic [15:0] LIM_ONE  = 16'h0080;
    localparam logic [15:0] LIM_TWO  = 16'h0800;
    localparam logic [7:0]  CONT_TAG = 8'h80;
    localparam logic [7:0]  LEAD_TWO = 8'hC0;
    localparam logic [7:0]  LEAD_THR = 8'hE0;
    localparam logic [7:0]  LEAD_FOUR = 8'hF0;

    // index of the final byte in an entry
    localparam logic [1:0] LAST_ONE  = 2'd0;
    localparam logic [1:0] LAST_TWO  = 2'd1;
    localparam logic [1:0] LAST_THR  = 2'd2;
    localparam logic [1:0] LAST_FOUR = 2'd3;

    // queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // one encoded code point, lead byte in slot 0
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
    } t_entry;

    // handshake between queue and back end
    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_head;

endpackage

`default_nettype wire

FILE: hdl/utt_front.sv
// ----------------------------------------------------------------------------
// utt_front
// Accepts code units, tracks the pending high surrogate and packs the
// UTF-8 bytes of each code point into one queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

module utt_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [15:0]   i_code_unit,
    input  wire logic          i_new_string,
    input  wire logic          i_full,
    output logic               o_push,
    output utt_pkg::t_entry    o_entry
);
    import utt_pkg::*;

    logic        r_pend;
    logic [9:0]  r_pend_bits;
    logic        n_pend;
    logic [9:0]  n_pend_bits;
    logic        is_high;
    logic        is_low;
    logic        pend_eff;
    logic        pair;
    logic        accept;
    logic [20:0] cp;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    // classify the unit
    always_comb begin
        is_high  = i_code_unit inside {[HI_FIRST:HI_LAST]};
        is_low   = i_code_unit inside {[LO_FIRST:LO_LAST]};
        pend_eff = r_pend && !i_new_string;
        pair     = pend_eff && is_low;
        // supplementary planes start at 0x10000, i.e. 0x40 above the high bits
        cp       = {{1'b0, r_pend_bits} + 11'h040, i_code_unit[9:0]};
    end

    // encode into bytes
    always_comb begin
        o_entry = '0;
        if (pair) begin
            o_entry.bytes[0] = LEAD_FOUR | {5'd0, cp[20:18]};
            o_entry.bytes[1] = CONT_TAG | {2'd0, cp[17:12]};
            o_entry.bytes[2] = CONT_TAG | {2'd0, cp[11:6]};
            o_entry.bytes[3] = CONT_TAG | {2'd0, cp[5:0]};
            o_entry.last_idx = LAST_FOUR;
        end else if (i_code_unit < LIM_ONE) begin
            o_entry.bytes[0] = i_code_unit[7:0];
            o_entry.last_idx = LAST_ONE;
        end else if (i_code_unit < LIM_TWO) begin
            o_entry.bytes[0] = LEAD_TWO | {3'd0, i_code_unit[10:6]};
            o_entry.bytes[1] = CONT_TAG | {2'd0, i_code_unit[5:0]};
            o_entry.last_idx = LAST_TWO;
        end else begin
            o_entry.bytes[0] = LEAD_THR | {4'd0, i_code_unit[15:12]};
            o_entry.bytes[1] = CONT_TAG | {2'd0, i_code_unit[11:6]};
            o_entry.bytes[2] = CONT_TAG | {2'd0, i_code_unit[5:0]};
            o_entry.last_idx = LAST_THR;
        end
    end

    assign o_push = accept && !is_high;

    // pending surrogate update
    always_comb begin
        n_pend      = r_pend;
        n_pend_bits = r_pend_bits;
        if (accept) begin
            n_pend = pend_eff;
            if (is_high) begin
                n_pend      = 1'b1;
                n_pend_bits = i_code_unit[9:0];
            end else if (pair) begin
                n_pend = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= n_pend;
        end
        r_pend_bits <= n_pend_bits;
    end

endmodule

`default_nettype wire

FILE: hdl/utt_queue.sv
// ----------------------------------------------------------------------------
// utt_queue
// Short entry queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module utt_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire utt_pkg::t_entry i_entry,
    output logic               o_full,
    output utt_pkg::t_head     o_head,
    input  wire logic          i_pop
);
    import utt_pkg::*;

    t_entry          r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_AW:0]   r_cnt;
    logic [Q_AW-1:0] n_wp;
    logic [Q_AW-1:0] n_rp;
    logic [Q_AW:0]   n_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_full       = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.entry = r_mem[r_rp];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_head.valid;

    // pointer and count update
    always_comb begin
        n_wp  = do_push ? r_wp + 1'b1 : r_wp;
        n_rp  = do_pop ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!do_push && do_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // storage write
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/utt_back.sv
// ----------------------------------------------------------------------------
// utt_back
// Walks the head entry one byte per beat into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module utt_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire utt_pkg::t_head i_head,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [7:0]         o_out_byte,
    output logic               o_last_byte
);
    import utt_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic [1:0] r_idx;
    logic       n_valid;
    logic [1:0] n_idx;
    logic       load;
    logic       at_end;

    // output register takes a byte when empty or being drained
    assign load   = i_head.valid && (!r_valid || i_ready);
    assign at_end = (r_idx == i_head.entry.last_idx);
    assign o_pop  = load && at_end;

    always_comb begin
        n_valid = r_valid;
        n_idx   = r_idx;
        if (load) begin
            n_valid = 1'b1;
            n_idx   = at_end ? 2'd0 : r_idx + 2'd1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
        if (load) begin
            r_byte <= i_head.entry.bytes[r_idx];
            r_last <= at_end;
        end
    end

    assign o_valid     = r_valid;
    assign o_out_byte  = r_byte;
    assign o_last_byte = r_last;

endmodule

`default_nettype wire

FILE: hdl/utf16_to_utf8_transcoder_top.sv
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_top
// UTF-16 code units in, UTF-8 bytes out, with a flag on the last byte.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------
//  input    | i_valid / o_ready  | i_code_unit[15:0], i_new_string
//  output   | o_valid / i_ready  | o_out_byte[7:0], o_last_byte
//
//  The output gives one byte per cycle while i_ready is high and an entry
//  waits; a code point gives 1..4 bytes, a high surrogate gives none.
//  Input is taken every cycle while the two-entry queue has room.
//  First byte of a unit is registered in the queue, then in the output register.
//  Synchronous reset clears the pending surrogate, queue and output.
// ----------------------------------------------------------------------------
`default_nettype none

module utf16_to_utf8_transcoder_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [15:0] i_code_unit,
    input  wire logic        i_new_string,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_out_byte,
    output logic             o_last_byte
);
    import utt_pkg::*;

    logic   push;
    logic   full;
    logic   pop;
    t_entry entry;
    t_head  head;

    // classify and encode
    utt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_code_unit  (i_code_unit),
        .i_new_string (i_new_string),
        .i_full       (full),
        .o_push       (push),
        .o_entry      (entry)
    );

    // decoupling queue
    utt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .o_full  (full),
        .o_head  (head),
        .i_pop   (pop)
    );

    // byte serializer
    utt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_byte  (o_out_byte),
        .o_last_byte (o_last_byte)
    );

endmodule

`default_nettype wire

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the UTF-16 to UTF-8 transcoder. A driver offers
// code units from a queue and a monitor checks every output byte against a
// transcoding model that keeps its own copy of the pending high surrogate.
// Both sides idle at random, the receiver stalls long once, and the sender
// waits for output to drain after the directed part and once or twice later.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    import utt_pkg::*;

    // one code unit to offer, or a marker to wait until the output drains
    typedef struct {
        logic [15:0] unit;
        logic        fresh;
        logic        drain;
    } t_unit_item;

    // one expected output beat
    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_utf8_byte;

    typedef enum int {K_ASCII, K_TWO, K_THREE, K_PAIR, K_NOISE} t_unit_kind;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic [15:0] i_code_unit  = '0;
    logic        i_new_string = 1'b0;
    logic        i_ready      = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [7:0]  o_out_byte;
    logic        o_last_byte;

    t_unit_item  units_q[$];
    t_utf8_byte  utf8_q[$];
    logic [15:0] held_high   = '0;
    int          units_sent  = 0;
    int          bytes_seen  = 0;
    int          errors      = 0;
    int          hold_cycles = 0;
    bit          hold_done   = 1'b0;

    utf16_to_utf8_transcoder_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_code_unit  (i_code_unit),
        .i_new_string (i_new_string),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_byte   (o_out_byte),
        .o_last_byte  (o_last_byte)
    );

    always #4 i_clk = ~i_clk;

    // queue one code unit for the driver
    function automatic void add_unit(input logic [15:0] unit, input logic fresh);
        t_unit_item it;
        it.unit  = unit;
        it.fresh = fresh;
        it.drain = 1'b0;
        units_q = {units_q, it};
    endfunction

    // queue a pause until every expected byte has come out
    function automatic void add_drain();
        t_unit_item it;
        it.unit  = '0;
        it.fresh = 1'b0;
        it.drain = 1'b1;
        units_q = {units_q, it};
    endfunction

    function automatic void push_byte(input logic [7:0] data, input logic last);
        t_utf8_byte b;
        b.data = data;
        b.last = last;
        utf8_q = {utf8_q, b};
    endfunction

    // utf-8 bytes of one code point, lead byte first
    function automatic void push_utf8(input logic [20:0] cp);
        if (cp < 21'(LIM_ONE)) begin
            push_byte(cp[7:0], 1'b1);
        end else if (cp < 21'(LIM_TWO)) begin
            push_byte(LEAD_TWO | {3'b000, cp[10:6]}, 1'b0);
            push_byte(CONT_TAG | {2'b00, cp[5:0]}, 1'b1);
        end else if (cp[20:16] == 5'd0) begin
            push_byte(LEAD_THR | {4'b0000, cp[15:12]}, 1'b0);
            push_byte(CONT_TAG | {2'b00, cp[11:6]}, 1'b0);
            push_byte(CONT_TAG | {2'b00, cp[5:0]}, 1'b1);
        end else begin
            push_byte(LEAD_FOUR | {5'b00000, cp[20:18]}, 1'b0);
            push_byte(CONT_TAG | {2'b00, cp[17:12]}, 1'b0);
            push_byte(CONT_TAG | {2'b00, cp[11:6]}, 1'b0);
            push_byte(CONT_TAG | {2'b00, cp[5:0]}, 1'b1);
        end
    endfunction

    // expected bytes for one accepted code unit, tracking the pending surrogate
    function automatic void transcode_unit(input logic [15:0] unit, input logic fresh);
        logic [20:0] cp;
        if (fresh)
            held_high = '0;
        if (unit >= HI_FIRST && unit <= HI_LAST) begin
            held_high = unit;
        end else if (held_high != '0 && unit >= LO_FIRST && unit <= LO_LAST) begin
            cp = 21'h10000 + (21'(held_high - HI_FIRST) << 10) + 21'(unit - LO_FIRST);
            held_high = '0;
            push_utf8(cp);
        end else begin
            push_utf8({5'b00000, unit});
        end
    endfunction

    // driver: offers one code unit per beat, idles at random
    always @(posedge i_clk) begin
        logic fire;
        logic offer;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            held_high = '0;
        end else begin
            fire  = i_valid && o_ready;
            offer = i_valid && !fire;
            if (fire) begin
                transcode_unit(i_code_unit, i_new_string);
                void'(units_q.pop_front());
                units_sent <= units_sent + 1;
            end
            if (!offer && units_q.size() > 0) begin
                if (units_q[0].drain) begin
                    if (utf8_q.size() == 0)
                        void'(units_q.pop_front());
                end else if ((units_sent >= 100 && units_sent < 130) ||
                             $urandom_range(99) >= 30) begin
                    offer = 1'b1;
                    i_code_unit  <= units_q[0].unit;
                    i_new_string <= units_q[0].fresh;
                end
            end
            i_valid <= offer;
        end
    end

    // long receiver stall once the stream is well under way
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
        end else if (!hold_done && units_sent == 70) begin
            hold_cycles <= 120;
            hold_done   <= 1'b1;
        end
    end

    // monitor: checks each output beat, stalls at random
    always @(posedge i_clk) begin
        t_utf8_byte want;
        logic       rdy;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                bytes_seen <= bytes_seen + 1;
                if (utf8_q.size() == 0) begin
                    $error("out_byte: no byte expected, actual %02h", o_out_byte);
                    errors++;
                end else begin
                    want = utf8_q.pop_front();
                    if (o_out_byte !== want.data) begin
                        $error("out_byte: expected %02h, actual %02h", want.data, o_out_byte);
                        errors++;
                    end
                    if (o_last_byte !== want.last) begin
                        $error("last_byte: expected %0b, actual %0b", want.last, o_last_byte);
                        errors++;
                    end
                end
            end
            if (hold_cycles > 0)
                rdy = 1'b0;
            else if (bytes_seen >= 150 && bytes_seen < 260)
                rdy = 1'b1;
            else
                rdy = ($urandom_range(99) >= 30);
            i_ready <= rdy;
        end
    end

    // stimulus, reset and end of run
    initial begin
        int         count;
        int         pick;
        t_unit_kind kind;

        // encoding boundaries
        add_unit(16'h0000, 1'b1);
        add_unit(16'h007F, 1'b0);
        add_unit(16'h0080, 1'b0);
        add_unit(16'h07FF, 1'b0);
        add_unit(16'h0800, 1'b0);
        add_unit(16'hD7FF, 1'b0);
        add_unit(16'hE000, 1'b0);
        add_unit(16'hFFFF, 1'b0);
        // lone low surrogates
        add_unit(LO_FIRST, 1'b0);
        add_unit(LO_LAST, 1'b0);
        // lowest and highest supplementary points
        add_unit(HI_FIRST, 1'b0);
        add_unit(LO_FIRST, 1'b0);
        add_unit(HI_LAST, 1'b0);
        add_unit(LO_LAST, 1'b0);
        // second high surrogate replaces the first
        add_unit(16'hD801, 1'b0);
        add_unit(16'hDB00, 1'b0);
        add_unit(16'hDC01, 1'b0);
        // plain unit in between keeps the pending surrogate
        add_unit(16'hD83D, 1'b0);
        add_unit(16'h0041, 1'b0);
        add_unit(16'hDE00, 1'b0);
        // new string drops the pending surrogate
        add_unit(16'hD800, 1'b0);
        add_unit(16'hDC00, 1'b1);
        add_unit(16'hDABC, 1'b1);
        add_unit(16'hDD55, 1'b0);
        add_drain();

        // random stream, mostly well formed
        count = 0;
        while (count < 106) begin
            pick = $urandom_range(99);
            kind = (pick < 30) ? K_ASCII :
                   (pick < 50) ? K_TWO   :
                   (pick < 70) ? K_THREE :
                   (pick < 88) ? K_PAIR  : K_NOISE;
            case (kind)
                K_ASCII: begin
                    add_unit(16'($urandom_range(16'h007F)), ($urandom_range(9) == 0));
                    count++;
                end
                K_TWO: begin
                    add_unit(16'($urandom_range(16'h07FF, 16'h0080)),
                             ($urandom_range(9) == 0));
                    count++;
                end
                K_THREE: begin
                    if ($urandom_range(1) == 0)
                        add_unit(16'($urandom_range(16'hD7FF, 16'h0800)),
                                 ($urandom_range(9) == 0));
                    else
                        add_unit(16'($urandom_range(16'hFFFF, 16'hE000)),
                                 ($urandom_range(9) == 0));
                    count++;
                end
                K_PAIR: begin
                    add_unit(16'($urandom_range(HI_LAST, HI_FIRST)), ($urandom_range(9) == 0));
                    add_unit(16'($urandom_range(LO_LAST, LO_FIRST)), ($urandom_range(19) == 0));
                    count += 2;
                end
                default: begin
                    if ($urandom_range(2) == 0)
                        add_unit(16'($urandom_range(HI_LAST, HI_FIRST)),
                                 ($urandom_range(3) == 0));
                    else
                        add_unit(16'($urandom_range(16'hFFFF)), ($urandom_range(1) == 0));
                    count++;
                end
            endcase
            if (count >= 90 && count < 92)
                add_drain();
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (units_q.size() > 0 || i_valid)
            @(posedge i_clk);
        while (utf8_q.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

FILE: utf16_to_utf8_transcoder_top.f
hdl/utt_pkg.sv
hdl/utt_front.sv
hdl/utt_queue.sv
hdl/utt_back.sv
hdl/utf16_to_utf8_transcoder_top.sv
bench/tb.sv
